// ===== hw/rtl/sfram_pkg.sv =====
package sfram_pkg;

	localparam int ADDR_BITS = 11;
	localparam int MEM_DEPTH = 1 << ADDR_BITS;

	localparam logic [7:0] OP_WRSR  = 8'h01;
	localparam logic [7:0] OP_WRITE = 8'h02;
	localparam logic [7:0] OP_READ  = 8'h03;
	localparam logic [7:0] OP_WRDI  = 8'h04;
	localparam logic [7:0] OP_RDSR  = 8'h05;
	localparam logic [7:0] OP_WREN  = 8'h06;

	localparam logic [7:0] ST_WPEN = 8'h80;
	localparam logic [7:0] ST_BP   = 8'h0C;

	typedef enum logic [4:0] {
		PH_OPCODE  = 5'b00001,
		PH_ADDR_HI = 5'b00010,
		PH_ADDR_LO = 5'b00100,
		PH_DATA    = 5'b01000,
		PH_IGNORE  = 5'b10000
	} phase_t;

	// memory access asked for by the frame parser
	typedef struct packed {
		logic                 we;
		logic                 re;
		logic [ADDR_BITS-1:0] addr;
		logic [7:0]           wdata;
	} mem_req_t;

	// result of one transaction, miso taken from memory when from_mem is set
	typedef struct packed {
		logic       from_mem;
		logic [7:0] miso;
		logic       stored;
		logic       latch;
	} res_t;

	function automatic logic [7:0] status_byte(logic wpen, logic [1:0] bp, logic wel);
		status_byte = {wpen, 3'b000, bp, wel, 1'b0};
	endfunction

	function automatic logic is_protected(logic [1:0] bp, logic [ADDR_BITS-1:0] addr);
		logic res;
		res = 1'b0;
		case (bp)
			2'b01:   res = (addr[ADDR_BITS-1:ADDR_BITS-2] == 2'b11);
			2'b10:   res = addr[ADDR_BITS-1];
			2'b11:   res = 1'b1;
			default: res = 1'b0;
		endcase
		is_protected = res;
	endfunction

endpackage

// ===== hw/rtl/sfram_ram.sv =====
module sfram_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== hw/rtl/sfram_ctrl.sv =====
module sfram_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic                command,
	input  logic [7:0]          mosi_byte,
	output sfram_pkg::mem_req_t req,
	output sfram_pkg::res_t     res
);
	import sfram_pkg::*;

	phase_t               phase_q, phase_d;
	logic [7:0]           op_q, op_d;
	logic [ADDR_BITS-1:0] addr_q, addr_d;
	logic                 wel_q, wel_d;
	logic [1:0]           bp_q, bp_d;
	logic                 wpen_q, wpen_d;
	logic [15:0]          hi_w, lo_w;
	logic [7:0]           bp_m;

	assign hi_w = {mosi_byte, 8'h00};
	assign lo_w = {8'h00, mosi_byte};
	assign bp_m = mosi_byte & ST_BP;

	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		addr_d  = addr_q;
		wel_d   = wel_q;
		bp_d    = bp_q;
		wpen_d  = wpen_q;
		req     = '0;
		res     = '0;
		req.addr  = addr_q;
		req.wdata = mosi_byte;
		if (command) begin
			if (phase_q != PH_OPCODE && (op_q == OP_WRITE || op_q == OP_WRSR)) begin
				wel_d = 1'b0;
			end
			phase_d = PH_OPCODE;
		end else begin
			case (phase_q)
				PH_OPCODE: begin
					op_d = mosi_byte;
					case (mosi_byte)
						OP_WREN: begin
							wel_d   = 1'b1;
							phase_d = PH_IGNORE;
						end
						OP_WRDI: begin
							wel_d   = 1'b0;
							phase_d = PH_IGNORE;
						end
						OP_READ, OP_WRITE: phase_d = PH_ADDR_HI;
						OP_RDSR, OP_WRSR:  phase_d = PH_DATA;
						default:           phase_d = PH_IGNORE;
					endcase
				end
				PH_ADDR_HI: begin
					addr_d  = hi_w[ADDR_BITS-1:0];
					phase_d = PH_ADDR_LO;
				end
				PH_ADDR_LO: begin
					addr_d  = addr_q | lo_w[ADDR_BITS-1:0];
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					case (op_q)
						OP_RDSR: res.miso = status_byte(wpen_q, bp_q, wel_q);
						OP_WRSR: begin
							if (wel_q) begin
								wpen_d = |(mosi_byte & ST_WPEN);
								bp_d   = bp_m[3:2];
							end
							phase_d = PH_IGNORE;
						end
						OP_READ: begin
							req.re       = 1'b1;
							res.from_mem = 1'b1;
							addr_d       = addr_q + 1'b1;
						end
						default: begin
							// write data phase: dropped without latch or in guarded region
							req.we     = wel_q && !is_protected(bp_q, addr_q);
							res.stored = req.we;
							addr_d     = addr_q + 1'b1;
						end
					endcase
				end
				default: ;
			endcase
		end
		res.latch = wel_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			op_q    <= '0;
			addr_q  <= '0;
			wel_q   <= 1'b0;
			bp_q    <= '0;
			wpen_q  <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			addr_q  <= addr_d;
			wel_q   <= wel_d;
			bp_q    <= bp_d;
			wpen_q  <= wpen_d;
		end
	end

endmodule

// ===== hw/rtl/spi_fram_memory_device_unit.sv =====
// channel | dir | tdata / tuser contents (lsb first)                  | accept
// s_*     | in  | tdata: mosi_byte[7:0]; tuser: command[0]            | s_tvalid & s_tready
// m_*     | out | tdata: miso_byte[7:0], stored[8], write_latch[9]    | m_tvalid & m_tready
//
// each transaction goes through accept (parse, issue memory access) and then a
// result stage that picks up the registered memory read data
// read data waits in the ram output register, so s_tready stays low while the result stage is full
// after reset a clearing pass zeroes all MEM_DEPTH (2048) words of the memory, with s_tready low
// the output register lets a new transaction be taken while a result waits on m_tready
module spi_fram_memory_device_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // mosi_byte[7:0]
	input  logic [0:0]  s_tuser,   // command[0]: 1 = chip deselect
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // miso_byte[7:0], stored[8], write_latch[9], zero above
);
	import sfram_pkg::*;

	logic                 acc;
	mem_req_t             req;
	res_t                 res;
	res_t                 res_s1;
	logic                 valid_s1;
	logic                 m_valid_q;
	logic [15:0]          m_data_q;
	logic [ADDR_BITS:0]   clr_cnt_q;
	logic                 clearing;
	logic                 load_out;
	logic                 ram_we;
	logic [ADDR_BITS-1:0] ram_addr;
	logic [7:0]           ram_wdata;
	logic [7:0]           ram_rdata;
	logic [7:0]           miso_s1;

	// clearing runs until the counter reaches the depth
	assign clearing = !clr_cnt_q[ADDR_BITS];
	// one transaction in flight between accept and the output register
	assign s_tready = !clearing && !valid_s1;
	assign acc      = s_tvalid && s_tready;
	assign load_out = valid_s1 && (!m_valid_q || m_tready);

	sfram_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.command   (s_tuser[0]),
		.mosi_byte (s_tdata),
		.req       (req),
		.res       (res)
	);

	// clearing pass owns the memory port until it is done
	assign ram_we    = clearing ? 1'b1 : (acc && req.we);
	assign ram_addr  = clearing ? clr_cnt_q[ADDR_BITS-1:0] : req.addr;
	assign ram_wdata = clearing ? 8'h00 : req.wdata;

	sfram_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (acc && req.re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// result stage: read data stays in the ram output register until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
	end

	assign miso_s1 = res_s1.from_mem ? ram_rdata : res_s1.miso;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q <= {6'b000000, res_s1.latch, res_s1.stored, miso_s1};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

// ===== test/spi_fram_memory_device_unit_tb.sv =====
`timescale 1ns / 100ps

module spi_fram_memory_device_unit_tb;

	import sfram_pkg::*;

	// a cycle with no transaction on either side counts toward the watchdog
	localparam int STALL_LIMIT = 10000;
	// long receiver hold-off, started once after this many results
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER  = 400;
	// random stimulus per idling phase
	localparam int PHASE_ITEMS = 540;

	// one byte exchange or a deselect, as offered on the slave side
	typedef struct packed {
		logic       deselect;
		logic [7:0] mosi;
	} spi_xfer_t;

	// what the device answers for one transaction
	typedef struct packed {
		logic [7:0] miso;
		logic       stored;
		logic       latch;
	} fram_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // mosi_byte[7:0]
	logic [0:0]  s_tuser = '0;   // command[0]: 1 = chip deselect
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // miso_byte[7:0], stored[8], write_latch[9]

	spi_xfer_t   xfer_q[$];
	fram_reply_t reply_q[$];
	fram_reply_t want;

	// device state as the host sees it
	phase_t                 xfer_phase = PH_OPCODE;
	logic [7:0]             xfer_op = '0;
	logic [ADDR_BITS-1:0]   xfer_addr = '0;
	logic                   wel = 1'b0;
	logic [1:0]             bp_bits = '0;
	logic                   wpen_bit = 1'b0;
	logic [7:0]             image [MEM_DEPTH];

	int unsigned send_gap_pct = 26;
	int unsigned recv_gap_pct = 45;
	int unsigned queued_items = 0;
	int unsigned error_count = 0;
	int unsigned results_checked = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	// coverage tallies for the closing summary
	int unsigned xfers_accepted = 0;
	int unsigned bytes_stored = 0;
	int unsigned bytes_dropped = 0;
	int unsigned mem_reads = 0;
	int unsigned status_reads = 0;

	spi_fram_memory_device_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// block-protect region: upper quarter, upper half or everything
	function automatic logic guarded(input logic [1:0] bits, input logic [ADDR_BITS-1:0] a);
		case (bits)
			2'd1:    return a >= ADDR_BITS'(MEM_DEPTH - MEM_DEPTH / 4);
			2'd2:    return a >= ADDR_BITS'(MEM_DEPTH / 2);
			2'd3:    return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// advance the device state by one transaction and return its answer
	function automatic fram_reply_t fram_transfer(input logic deselect, input logic [7:0] mosi);
		fram_reply_t r;
		logic [15:0] wide;
		r = '0;
		if (deselect) begin
			// a write or status-write frame drops the latch when it ends, cut short or not
			if (xfer_phase != PH_OPCODE && (xfer_op == OP_WRITE || xfer_op == OP_WRSR))
				wel = 1'b0;
			xfer_phase = PH_OPCODE;
		end else begin
			case (xfer_phase)
				PH_OPCODE: begin
					xfer_op = mosi;
					case (mosi)
						OP_WREN: begin
							wel = 1'b1;
							xfer_phase = PH_IGNORE;
						end
						OP_WRDI: begin
							wel = 1'b0;
							xfer_phase = PH_IGNORE;
						end
						OP_READ, OP_WRITE: xfer_phase = PH_ADDR_HI;
						OP_RDSR, OP_WRSR:  xfer_phase = PH_DATA;
						default:           xfer_phase = PH_IGNORE;
					endcase
				end
				PH_ADDR_HI: begin
					// high address bits beyond the array are dropped
					wide = {mosi, 8'h00};
					xfer_addr = wide[ADDR_BITS-1:0];
					xfer_phase = PH_ADDR_LO;
				end
				PH_ADDR_LO: begin
					xfer_addr[7:0] = mosi;
					xfer_phase = PH_DATA;
				end
				PH_DATA: begin
					case (xfer_op)
						OP_RDSR: begin
							r.miso = {wpen_bit, 3'b000, bp_bits, wel, 1'b0};
							status_reads++;
						end
						OP_WRSR: begin
							// only the first byte counts, and only with the latch set
							if (wel) begin
								wpen_bit = mosi[7];
								bp_bits = mosi[3:2];
							end
							xfer_phase = PH_IGNORE;
						end
						OP_READ: begin
							r.miso = image[xfer_addr];
							xfer_addr = xfer_addr + 1'b1;
							mem_reads++;
						end
						default: begin
							if (wel && !guarded(bp_bits, xfer_addr)) begin
								image[xfer_addr] = mosi;
								r.stored = 1'b1;
								bytes_stored++;
							end else begin
								bytes_dropped++;
							end
							xfer_addr = xfer_addr + 1'b1;
						end
					endcase
				end
				default: ;
			endcase
		end
		r.latch = wel;
		return r;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
		xfer_q.push_back('{deselect: 1'b0, mosi: b});
		if (counted)
			queued_items++;
	endtask

	// deselect carries a random byte so that its data bits move too
	task automatic end_frame();
		logic [7:0] junk;
		junk = 8'($urandom);
		xfer_q.push_back('{deselect: 1'b1, mosi: junk});
		queued_items++;
	endtask

	// unused upper bits of the high byte are random
	task automatic send_address(input logic [ADDR_BITS-1:0] a);
		logic [15:0] w;
		w = 16'($urandom);
		w[ADDR_BITS-1:0] = a;
		send_byte(w[15:8]);
		send_byte(w[7:0]);
	endtask

	// mostly windows around the bottom, the protect boundaries and the top, for wrap and reuse
	function automatic logic [ADDR_BITS-1:0] pick_address();
		logic [ADDR_BITS-1:0] a;
		case ($urandom_range(4))
			0:       a = '0;
			1:       a = ADDR_BITS'(MEM_DEPTH / 2 - 8);
			2:       a = ADDR_BITS'(MEM_DEPTH - MEM_DEPTH / 4 - 8);
			3:       a = ADDR_BITS'(MEM_DEPTH - 8);
			default: a = ADDR_BITS'($urandom_range(MEM_DEPTH - 1));
		endcase
		return a + ADDR_BITS'($urandom_range(15));
	endfunction

	task automatic enable_writes();
		send_byte(OP_WREN);
		if ($urandom_range(9) == 0)
			send_byte(8'($urandom), 1'b0);
		end_frame();
	endtask

	task automatic queue_random_frame();
		int unsigned kind;
		int unsigned n;
		logic [7:0] b;
		kind = $urandom_range(99);
		if (kind < 35) begin
			// write burst, usually behind a latch enable
			if ($urandom_range(99) < 85)
				enable_writes();
			send_byte(OP_WRITE);
			if ($urandom_range(99) < 8) begin
				if ($urandom_range(1))
					send_byte(8'($urandom));
			end else begin
				send_address(pick_address());
				n = $urandom_range(6, 1);
				repeat (n) send_byte(8'($urandom));
			end
			end_frame();
		end else if (kind < 60) begin
			send_byte(OP_READ);
			send_address(pick_address());
			n = $urandom_range(6, 1);
			repeat (n) send_byte(8'($urandom));
			end_frame();
		end else if (kind < 70) begin
			send_byte(OP_RDSR);
			n = $urandom_range(3, 1);
			repeat (n) send_byte(8'($urandom));
			end_frame();
		end else if (kind < 80) begin
			// status write, leaning toward clearing block protect
			if ($urandom_range(99) < 70)
				enable_writes();
			send_byte(OP_WRSR);
			b = 8'($urandom);
			if ($urandom_range(99) < 60)
				b[3:2] = 2'b00;
			send_byte(b);
			if ($urandom_range(3) == 0)
				send_byte(8'($urandom));
			end_frame();
		end else if (kind < 85) begin
			send_byte(OP_WRDI);
			if ($urandom_range(3) == 0)
				send_byte(8'($urandom), 1'b0);
			end_frame();
		end else if (kind < 93) begin
			// opcode the device does not know
			do
				b = 8'($urandom);
			while (b >= OP_WRSR && b <= OP_WREN);
			send_byte(b);
			n = $urandom_range(2);
			repeat (n) send_byte(8'($urandom), 1'b0);
			end_frame();
		end else begin
			case ($urandom_range(2))
				0: end_frame();
				1: begin
					// read frame left open, so the next opcode lands in its data phase
					send_byte(OP_READ);
					send_address(pick_address());
					send_byte(8'($urandom));
				end
				default: begin
					send_byte(8'($urandom));
					end_frame();
				end
			endcase
		end
	endtask

	// driver: holds each transaction until accepted, predicts it on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				reply_q.push_back(fram_transfer(s_tuser[0], s_tdata));
				xfers_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (xfer_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					s_tvalid <= 1'b1;
					s_tuser[0] <= xfer_q[0].deselect;
					s_tdata <= xfer_q[0].mosi;
					void'(xfer_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result against the oldest prediction, drives the stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					$error("result transaction with nothing predicted, m_tdata %04h", m_tdata);
					error_count++;
				end else begin
					want = reply_q.pop_front();
					if (m_tdata[7:0] !== want.miso) begin
						$error("miso_byte: expected %02h, got %02h", want.miso, m_tdata[7:0]);
						error_count++;
					end
					if (m_tdata[8] !== want.stored) begin
						$error("stored: expected %0b, got %0b", want.stored, m_tdata[8]);
						error_count++;
					end
					if (m_tdata[9] !== want.latch) begin
						$error("write_latch: expected %0b, got %0b", want.latch, m_tdata[9]);
						error_count++;
					end
				end
				results_checked++;
			end
			// one long hold-off lets the device fill up and push back on its input
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!hold_done && results_checked >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_gap_pct);
			end
		end
	end

	// watchdog: too long with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("spi_fram_memory_device_unit test failed");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < MEM_DEPTH; i++)
			image[i] = 8'h00;

		// directed opening
		end_frame();                                       // deselect with no frame open
		send_byte(OP_WRITE);                               // write at the top, latch clear
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hA5);
		end_frame();
		enable_writes();
		send_byte(OP_WRSR);                                // wpen and full protect
		send_byte(8'hFF);
		send_byte(8'hFF);                                  // extra status byte
		end_frame();                                       // latch drops here
		send_byte(OP_RDSR);
		send_byte(8'h00);
		end_frame();
		send_byte(OP_WREN);
		end_frame();
		send_byte(OP_WRITE);                               // whole array guarded
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h5A);
		end_frame();
		send_byte(OP_WRDI);
		end_frame();
		send_byte(8'hFF);                                  // unknown opcode
		send_byte(8'h00, 1'b0);
		end_frame();
		send_byte(OP_READ);                                // read at the top of memory
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		end_frame();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// three idling phases: sender-heavy, receiver-heavy swapped, then none
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_gap_pct = 26;
					recv_gap_pct = 45;
				end
				1: begin
					send_gap_pct = 45;
					recv_gap_pct = 26;
				end
				default: begin
					send_gap_pct = 0;
					recv_gap_pct = 0;
				end
			endcase
			for (int unsigned goal = queued_items + PHASE_ITEMS; queued_items < goal; )
				queue_random_frame();
			while (xfer_q.size() != 0 || s_tvalid)
				@(posedge clk);
		end

		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d transactions: %0d bytes written, %0d writes dropped",
			xfers_accepted, bytes_stored, bytes_dropped);
		$display("%0d memory reads, %0d status reads, %0d mismatches",
			mem_reads, status_reads, error_count);
		if (error_count == 0)
			$display("spi_fram_memory_device_unit test passed");
		else
			$display("spi_fram_memory_device_unit test failed");
		$finish;
	end

endmodule
